// ----- hdl/deq_pkg.sv -----
// Shared constants, types and ring-index helpers for the double-ended queue.
package deq_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int OP_W  = 2;
    localparam int ID_W  = 31;
    localparam int SAL_W = 31;
    localparam int REC_W = ID_W + SAL_W;

    localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
    localparam logic [OP_W-1:0] OP_POP  = 2'd1;
    localparam logic [OP_W-1:0] OP_PEEK = 2'd2;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;

    typedef struct packed {
        logic take;
        logic load;
    } deq_cmd_t;

    function automatic idx_t idx_inc(input idx_t i);
        return (i == IDX_W'(DEPTH - 1)) ? '0 : idx_t'(i + 1'b1);
    endfunction

    function automatic idx_t idx_dec(input idx_t i);
        return (i == '0) ? IDX_W'(DEPTH - 1) : idx_t'(i - 1'b1);
    endfunction

endpackage

// ----- hdl/deq_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module deq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- hdl/deq_ctrl.sv -----
// Controller: request acceptance, result load and output valid handling.
module deq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    output deq_pkg::deq_cmd_t cmd
);
    import deq_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_LOAD = 1'b1;

    logic state_reg;
    logic state_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic out_busy;

    assign out_busy  = out_valid_reg && out_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd.take   = 1'b0;
        cmd.load   = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (!out_busy)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> out_valid)
        else $error("loaded result not presented");

endmodule

// ----- hdl/deq_dp.sv -----
// Datapath: ring pointers, fill count, slot RAM and result register.
module deq_dp (
    input  logic                       clk,
    input  logic                       rst_n,
    input  deq_pkg::deq_cmd_t          cmd,
    input  logic [deq_pkg::OP_W-1:0]   op,
    input  logic                       from_left,
    input  logic [deq_pkg::ID_W-1:0]   rec_id,
    input  logic [deq_pkg::SAL_W-1:0]  rec_salary,
    output logic                       ok,
    output logic [deq_pkg::ID_W-1:0]   out_id,
    output logic [deq_pkg::SAL_W-1:0]  out_salary,
    output logic                       is_empty,
    output logic                       is_full
);
    import deq_pkg::*;

    idx_t left_reg;
    idx_t left_next;
    idx_t right_reg;
    idx_t right_next;
    cnt_t count_reg;
    cnt_t count_next;

    logic ok_pend_reg;
    logic rd_pend_reg;

    logic out_ok_reg;
    logic [ID_W-1:0]  out_id_reg;
    logic [SAL_W-1:0] out_sal_reg;
    logic out_empty_reg;
    logic out_full_reg;

    logic q_empty;
    logic q_full;
    logic is_push;
    logic is_read;
    logic push_ok;
    logic read_ok;

    logic             wr_en;
    idx_t             wr_addr;
    logic             rd_en;
    idx_t             rd_addr;
    logic [REC_W-1:0] rd_data;

    assign q_empty = (count_reg == '0);
    assign q_full  = (count_reg == CNT_W'(DEPTH));
    assign is_push = (op == OP_PUSH);
    assign is_read = (op == OP_POP) || (op == OP_PEEK);
    assign push_ok = is_push && !q_full;
    assign read_ok = is_read && !q_empty;

    assign wr_en   = cmd.take && push_ok;
    assign wr_addr = from_left ? idx_dec(left_reg) : right_reg;
    assign rd_en   = cmd.take && read_ok;
    assign rd_addr = from_left ? left_reg : idx_dec(right_reg);

    deq_ram #(
        .WIDTH (REC_W),
        .DEPTH (DEPTH)
    ) u_slots (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data ({rec_id, rec_salary}),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        left_next  = left_reg;
        right_next = right_reg;
        count_next = count_reg;
        if (wr_en)
        begin
            if (from_left)
            begin
                left_next = wr_addr;
            end
            else
            begin
                right_next = idx_inc(right_reg);
            end
            count_next = cnt_t'(count_reg + 1'b1);
        end
        else if (rd_en && (op == OP_POP))
        begin
            if (from_left)
            begin
                left_next = idx_inc(left_reg);
            end
            else
            begin
                right_next = rd_addr;
            end
            count_next = cnt_t'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg  <= '0;
            right_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            left_reg  <= left_next;
            right_reg <= right_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            ok_pend_reg <= push_ok || read_ok;
            rd_pend_reg <= read_ok;
        end
        if (cmd.load)
        begin
            out_ok_reg    <= ok_pend_reg;
            out_id_reg    <= rd_pend_reg ? rd_data[REC_W-1:SAL_W] : '0;
            out_sal_reg   <= rd_pend_reg ? rd_data[SAL_W-1:0] : '0;
            out_empty_reg <= q_empty;
            out_full_reg  <= q_full;
        end
    end

    assign ok         = out_ok_reg;
    assign out_id     = out_id_reg;
    assign out_salary = out_sal_reg;
    assign is_empty   = out_empty_reg;
    assign is_full    = out_full_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("fill count beyond depth");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> (count_reg == cnt_t'($past(count_reg) + 1'b1)))
        else $error("push did not advance fill count");

    a_ring_meet: assert property (@(posedge clk) disable iff (!rst_n)
        (q_empty || q_full) |-> (left_reg == right_reg))
        else $error("ring pointers disagree with fill count");

endmodule

// ----- hdl/double_ended_queue.sv -----
// Top level of the double-ended queue: controller plus datapath.
// A bounded double-ended queue of 16 records (31-bit identifier, 31-bit salary).
// Each request pushes, pops or peeks at the left or right end and answers with
// one result: ok, the record read (zero for a push or a failed request), and the
// empty and full flags after the request. A push into a full queue or a pop/peek
// on an empty one gives ok=0 and leaves the queue as it was; op code 3 does the
// same. Requests are taken only while idle: the slot store has a registered read
// port, so the record is loaded into the result register in the load state after
// acceptance. The next request may be taken while a result waits on out_stall,
// but its own result load holds until the output register frees.
module double_ended_queue (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [deq_pkg::OP_W-1:0]   op,
    input  logic                       from_left,
    input  logic [deq_pkg::ID_W-1:0]   rec_id,
    input  logic [deq_pkg::SAL_W-1:0]  rec_salary,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic                       ok,
    output logic [deq_pkg::ID_W-1:0]   out_id,
    output logic [deq_pkg::SAL_W-1:0]  out_salary,
    output logic                       is_empty,
    output logic                       is_full
);
    import deq_pkg::*;

    deq_cmd_t cmd;

    deq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    deq_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .op         (op),
        .from_left  (from_left),
        .rec_id     (rec_id),
        .rec_salary (rec_salary),
        .ok         (ok),
        .out_id     (out_id),
        .out_salary (out_salary),
        .is_empty   (is_empty),
        .is_full    (is_full)
    );

endmodule
